### src/dcods_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcods_pkg
// Shared types, widths and constants for the oscillator divider search core.
// ----------------------------------------------------------------------------
package dcods_pkg;

	localparam int TARGET_W        = 31;
	localparam int FX_W            = 51;
	localparam int FX_FRAC_BITS    = 24;
	localparam int FDCO_W          = 33;
	localparam int RFREQ_FRAC_BITS = 28;
	localparam int RF_W            = 10 + RFREQ_FRAC_BITS;
	localparam int LH_W            = FDCO_W + 1;
	localparam int SAT_SHIFT       = FX_FRAC_BITS + RFREQ_FRAC_BITS - RF_W;
	localparam int N1_W            = 8;
	localparam int HS_W            = 4;
	localparam int IDX_W           = 3;
	localparam int HS_N            = 6;
	localparam int HS_MAX          = 11;
	localparam int RECIP_SHIFT     = 16;
	localparam int RECIP_W         = RECIP_SHIFT + 1;
	localparam int CNT_W           = 4;
	localparam int DIV_CW          = 6;
	localparam int CMP_W           = RF_W + 17;

	localparam logic [FX_W-1:0]   FXTAL_RST = 51'd1917391638528000;
	localparam logic [FDCO_W-1:0] FMIN_RST  = 33'd4850000000;
	localparam logic [FDCO_W-1:0] FMAX_RST  = 33'd5670000000;
	localparam logic [RF_W-1:0]   RF_MAX    = '1;

	// large change threshold: diff * PCT_DEN >= anchor * PCT_NUM
	localparam logic [16:0] PCT_DEN = 17'd100000;
	localparam logic [16:0] PCT_NUM = 17'd345;

	localparam logic [7:0] ADDR_FREEZE = 8'd137;
	localparam logic [7:0] ADDR_CTRL   = 8'd135;
	localparam logic [7:0] REG_FIRST   = 8'd7;
	localparam logic [7:0] MASK_FRZ_DCO = 8'h10;
	localparam logic [7:0] MASK_FRZ_M   = 8'h20;
	localparam logic [7:0] MASK_NEWFREQ = 8'h40;

	localparam logic [CNT_W-1:0] N_ERR   = 4'd1;
	localparam logic [CNT_W-1:0] N_LARGE = 4'd9;
	localparam logic [CNT_W-1:0] N_SMALL = 4'd7;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_SET   = 2'd1,
		OP_CLEAR = 2'd2
	} reg_op_t;

	typedef enum logic [1:0] {
		CFG_FXTAL = 2'd0,
		CFG_FMIN  = 2'd1,
		CFG_FMAX  = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		DIV_LO = 2'd0,
		DIV_HI = 2'd1,
		DIV_RF = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic [7:0] reg_addr;
		logic [1:0] reg_op;
		logic [7:0] reg_data;
		logic       no_divider;
		logic       large_change;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic             load;
		logic             div_start;
		div_sel_t         div_sel;
		logic             cap_lo;
		logic             cap_hi;
		logic             search_init;
		logic             search_step;
		logic             found;
		logic             mul;
		logic             rf_sat;
		logic             rf_cap;
		logic             diff;
		logic             judge;
		logic             upd_anchor;
		logic             set_err;
		logic             emit;
		logic [CNT_W-1:0] k;
	} dp_cmd_t;

	typedef struct packed {
		logic f_zero;
		logic div_busy;
		logic range_empty;
		logic cand_ok;
		logic search_end;
		logic rf_sat_cond;
		logic large_chg;
		logic err;
		logic slot_free;
	} dp_sts_t;

	// high-speed divider order of the search
	function automatic logic [HS_W-1:0] hs_of(input logic [IDX_W-1:0] idx);
		case (idx)
			3'd0:    hs_of = 4'd11;
			3'd1:    hs_of = 4'd9;
			3'd2:    hs_of = 4'd7;
			3'd3:    hs_of = 4'd6;
			3'd4:    hs_of = 4'd5;
			default: hs_of = 4'd4;
		endcase
	endfunction

	// ceil(2^16 / hs)
	function automatic logic [RECIP_W-1:0] recip_of(input logic [IDX_W-1:0] idx);
		case (idx)
			3'd0:    recip_of = 17'd5958;
			3'd1:    recip_of = 17'd7282;
			3'd2:    recip_of = 17'd9363;
			3'd3:    recip_of = 17'd10923;
			3'd4:    recip_of = 17'd13108;
			default: recip_of = 17'd16384;
		endcase
	endfunction

endpackage

### src/dcods_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcods channel interfaces
// Request, result and configuration channels with valid/ready transfer.
// ----------------------------------------------------------------------------
interface dcods_in_if;
	logic        valid;
	logic        ready;
	logic [30:0] target_hz;
	modport source (output valid, output target_hz, input ready);
	modport sink   (input valid, input target_hz, output ready);
endinterface

interface dcods_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] reg_addr;
	logic [1:0] reg_op;
	logic [7:0] reg_data;
	logic       no_divider;
	logic       large_change;
	logic       last;
	modport source (output valid, output reg_addr, output reg_op, output reg_data,
		output no_divider, output large_change, output last, input ready);
	modport sink   (input valid, input reg_addr, input reg_op, input reg_data,
		input no_divider, input large_change, input last, output ready);
endinterface

interface dcods_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [50:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### src/dcods_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcods_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module dcods_div #(
	parameter int RW = 51,
	parameter int QW = 38,
	parameter int CW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [RW-1:0] rem_init,
	input  logic [QW-1:0] num,
	input  logic [RW-1:0] divisor,
	input  logic [CW-1:0] steps,
	output logic          busy,
	output logic [QW-1:0] quo
);

	logic [CW-1:0] cnt_q;
	logic [RW-1:0] rem_q;
	logic [QW-1:0] z_q;
	logic [RW:0]   trial;
	logic [RW:0]   sub;
	logic          ge;

	assign busy  = (cnt_q != '0);
	assign quo   = z_q;
	assign trial = {rem_q, z_q[QW-1]};
	assign ge    = (trial >= {1'b0, divisor});
	assign sub   = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= steps;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			z_q   <= num;
		end else if (busy) begin
			rem_q <= ge ? sub[RW-1:0] : trial[RW-1:0];
			z_q   <= {z_q[QW-2:0], ge};
		end
	end

endmodule

### src/dcods_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcods_dp
// Datapath: configuration, divider bounds, candidate search, RFREQ, output.
// ----------------------------------------------------------------------------
module dcods_dp import dcods_pkg::*; #(
	parameter int OUT_DIV_MAX = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [1:0]          cfg_index,
	input  logic [FX_W-1:0]     cfg_data,
	output logic                cfg_ready,
	input  logic [TARGET_W-1:0] target_hz,
	input  dp_cmd_t             cmd,
	output dp_sts_t             sts,
	input  logic                out_ready,
	output logic                out_valid,
	output out_item_t           out_item
);

	localparam int HI_MAX = HS_MAX * OUT_DIV_MAX;
	localparam int DW     = $clog2(HI_MAX + 1);
	localparam int PW     = TARGET_W + DW;
	localparam int SW     = (PW + SAT_SHIFT > FX_W) ? PW + SAT_SHIFT : FX_W;

	logic [FX_W-1:0]     fxtal_q;
	logic [FDCO_W-1:0]   fmin_q, fmax_q;
	logic [RF_W-1:0]     anchor_rf_q;
	logic [N1_W-1:0]     anchor_n1_q;
	logic [HS_W-1:0]     anchor_hs_q;
	logic [TARGET_W-1:0] f_q;
	logic [LH_W-1:0]     lo_q, hi_q;
	logic [DW-1:0]       d_q;
	logic [IDX_W-1:0]    idx_q;
	logic [N1_W-1:0]     n1_q;
	logic [HS_W-1:0]     hs_q;
	logic [PW-1:0]       p_q;
	logic [RF_W-1:0]     rf_q, diff_q;
	logic                large_q, err_q, ov_q;
	out_item_t           item_q;

	logic [LH_W-1:0]          lo_num, lo_eff, hi_eff;
	logic [FX_W-1:0]          dv_rem, dv_div;
	logic [RF_W-1:0]          dv_num, dv_quo;
	logic [DIV_CW-1:0]        dv_steps;
	logic                     dv_busy;
	logic [RECIP_W-1:0]       recip;
	logic [DW+RECIP_W-1:0]    prod;
	logic [DW-1:0]            qn;
	logic                     divisible;
	logic [SW-1:0]            p_sh;
	logic [N1_W-1:0]          n1code;
	logic [HS_W-1:0]          hsm4;
	logic [7:0]               regs [HS_N];
	logic [IDX_W-1:0]         ri;
	out_item_t                item_d;

	assign cfg_ready = 1'b1;
	assign out_valid = ov_q;
	assign out_item  = item_q;

	// bounds of the total divider
	assign lo_num = LH_W'(fmin_q) + LH_W'(f_q) - 1'b1;
	assign lo_eff = (lo_q == '0) ? LH_W'(1) : lo_q;
	assign hi_eff = (hi_q > LH_W'(HI_MAX)) ? LH_W'(HI_MAX) : hi_q;

	always_comb begin
		dv_rem   = '0;
		dv_div   = FX_W'(f_q);
		dv_num   = {lo_num, {(RF_W-LH_W){1'b0}}};
		dv_steps = DIV_CW'(LH_W);
		case (cmd.div_sel)
			DIV_LO: begin
				dv_num = {lo_num, {(RF_W-LH_W){1'b0}}};
			end
			DIV_HI: begin
				dv_num = {LH_W'(fmax_q), {(RF_W-LH_W){1'b0}}};
			end
			DIV_RF: begin
				dv_rem   = FX_W'(p_sh);
				dv_div   = fxtal_q;
				dv_num   = '0;
				dv_steps = DIV_CW'(RF_W);
			end
			default: begin
				dv_num = '0;
			end
		endcase
	end

	dcods_div #(
		.RW(FX_W),
		.QW(RF_W),
		.CW(DIV_CW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.rem_init(dv_rem),
		.num     (dv_num),
		.divisor (dv_div),
		.steps   (dv_steps),
		.busy    (dv_busy),
		.quo     (dv_quo)
	);

	// d divisible by hs iff the low product bits fall below the reciprocal
	assign recip     = recip_of(idx_q);
	assign prod      = DW'(d_q) * recip;
	assign qn        = prod[RECIP_SHIFT +: DW];
	assign divisible = (prod[RECIP_SHIFT-1:0] < recip[RECIP_SHIFT-1:0]) ||
		(recip[RECIP_SHIFT] == 1'b1);

	// RFREQ overflows exactly when p * 2^14 reaches fxtal
	assign p_sh = SW'(p_q) << SAT_SHIFT;

	assign n1code = (n1_q == N1_W'(1)) ? '0 : n1_q - 1'b1;
	assign hsm4   = hs_q - 4'd4;
	assign regs[0] = {hsm4[2:0], n1code[6:2]};
	assign regs[1] = {n1code[1:0], rf_q[37:32]};
	assign regs[2] = rf_q[31:24];
	assign regs[3] = rf_q[23:16];
	assign regs[4] = rf_q[15:8];
	assign regs[5] = rf_q[7:0];
	assign ri      = large_q ? IDX_W'(cmd.k - 1'b1) : IDX_W'(cmd.k);

	always_comb begin
		item_d              = '0;
		item_d.reg_addr     = REG_FIRST + 8'(ri);
		item_d.reg_op       = OP_WRITE;
		item_d.reg_data     = regs[ri];
		item_d.large_change = large_q;
		if (err_q) begin
			item_d          = '0;
			item_d.no_divider = 1'b1;
			item_d.last     = 1'b1;
		end else if (large_q) begin
			case (cmd.k)
				4'd0: begin
					item_d.reg_addr = ADDR_FREEZE;
					item_d.reg_op   = OP_SET;
					item_d.reg_data = MASK_FRZ_DCO;
				end
				4'd7: begin
					item_d.reg_addr = ADDR_FREEZE;
					item_d.reg_op   = OP_CLEAR;
					item_d.reg_data = MASK_FRZ_DCO;
				end
				4'd8: begin
					item_d.reg_addr = ADDR_CTRL;
					item_d.reg_op   = OP_SET;
					item_d.reg_data = MASK_NEWFREQ;
					item_d.last     = 1'b1;
				end
				default: begin
					item_d.reg_op = OP_WRITE;
				end
			endcase
		end else begin
			case (cmd.k)
				4'd0: begin
					item_d.reg_addr = ADDR_CTRL;
					item_d.reg_op   = OP_SET;
					item_d.reg_data = MASK_FRZ_M;
				end
				4'd6: begin
					item_d.reg_addr = ADDR_CTRL;
					item_d.reg_op   = OP_CLEAR;
					item_d.reg_data = MASK_FRZ_M;
					item_d.last     = 1'b1;
				end
				default: begin
					item_d.reg_op = OP_WRITE;
				end
			endcase
		end
	end

	assign sts.f_zero      = (f_q == '0);
	assign sts.div_busy    = dv_busy;
	assign sts.range_empty = (lo_eff > hi_eff);
	assign sts.cand_ok     = divisible && ((qn == DW'(1)) || !qn[0]) &&
		(qn <= DW'(OUT_DIV_MAX));
	assign sts.search_end  = (idx_q == IDX_W'(HS_N - 1)) && (LH_W'(d_q) == hi_eff);
	assign sts.rf_sat_cond = (fxtal_q == '0) || (p_sh >= SW'(fxtal_q));
	assign sts.large_chg   = large_q;
	assign sts.err         = err_q;
	assign sts.slot_free   = !ov_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fxtal_q     <= FXTAL_RST;
			fmin_q      <= FMIN_RST;
			fmax_q      <= FMAX_RST;
			anchor_rf_q <= '0;
			anchor_n1_q <= '0;
			anchor_hs_q <= '0;
			err_q       <= 1'b0;
			large_q     <= 1'b0;
			ov_q        <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FXTAL: begin
						fxtal_q     <= cfg_data;
						anchor_rf_q <= '0;
					end
					CFG_FMIN: fmin_q <= cfg_data[FDCO_W-1:0];
					CFG_FMAX: fmax_q <= cfg_data[FDCO_W-1:0];
					default: begin
						fmin_q <= fmin_q;
					end
				endcase
			end
			if (cmd.load) begin
				err_q <= 1'b0;
			end else if (cmd.set_err) begin
				err_q <= 1'b1;
			end
			if (cmd.judge) begin
				large_q <= (anchor_rf_q == '0) || (hs_q != anchor_hs_q) ||
					(n1_q != anchor_n1_q) ||
					(CMP_W'(diff_q) * CMP_W'(PCT_DEN) >= CMP_W'(anchor_rf_q) * CMP_W'(PCT_NUM));
			end
			if (cmd.upd_anchor && large_q) begin
				anchor_rf_q <= rf_q;
				anchor_n1_q <= n1_q;
				anchor_hs_q <= hs_q;
			end
			if (cmd.emit) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			f_q <= target_hz;
		end
		if (cmd.cap_lo) begin
			lo_q <= dv_quo[LH_W-1:0];
		end
		if (cmd.cap_hi) begin
			hi_q <= dv_quo[LH_W-1:0];
		end
		if (cmd.search_init) begin
			d_q   <= lo_eff[DW-1:0];
			idx_q <= '0;
		end else if (cmd.search_step) begin
			if (idx_q == IDX_W'(HS_N - 1)) begin
				idx_q <= '0;
				d_q   <= d_q + 1'b1;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
		if (cmd.found) begin
			n1_q <= N1_W'(qn);
			hs_q <= hs_of(idx_q);
		end
		if (cmd.mul) begin
			p_q <= PW'(f_q) * PW'(d_q);
		end
		if (cmd.rf_sat) begin
			rf_q <= RF_MAX;
		end else if (cmd.rf_cap) begin
			rf_q <= dv_quo;
		end
		if (cmd.diff) begin
			diff_q <= (rf_q >= anchor_rf_q) ? rf_q - anchor_rf_q : anchor_rf_q - rf_q;
		end
		if (cmd.emit) begin
			item_q <= item_d;
		end
	end

endmodule

### src/dcods_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcods_ctrl
// Sequencer: bounds, search, RFREQ, change test and result emission.
// ----------------------------------------------------------------------------
module dcods_ctrl import dcods_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [13:0] {
		S_IDLE    = 14'b00000000000001,
		S_LO_GO   = 14'b00000000000010,
		S_LO_WAIT = 14'b00000000000100,
		S_HI_GO   = 14'b00000000001000,
		S_HI_WAIT = 14'b00000000010000,
		S_RANGE   = 14'b00000000100000,
		S_SEARCH  = 14'b00000001000000,
		S_MUL     = 14'b00000010000000,
		S_RF_GO   = 14'b00000100000000,
		S_RF_WAIT = 14'b00001000000000,
		S_DIFF    = 14'b00010000000000,
		S_JUDGE   = 14'b00100000000000,
		S_UPD     = 14'b01000000000000,
		S_EMIT    = 14'b10000000000000
	} state_t;

	state_t           state_q, nxt;
	logic [CNT_W-1:0] k_q, count;

	assign count = sts.err ? N_ERR : (sts.large_chg ? N_LARGE : N_SMALL);

	always_comb begin
		cmd      = '0;
		cmd.k    = k_q;
		nxt      = state_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					nxt      = S_LO_GO;
				end
			end
			S_LO_GO: begin
				if (sts.f_zero) begin
					cmd.set_err = 1'b1;
					nxt         = S_EMIT;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_LO;
					nxt           = S_LO_WAIT;
				end
			end
			S_LO_WAIT: begin
				if (!sts.div_busy) begin
					cmd.cap_lo = 1'b1;
					nxt        = S_HI_GO;
				end
			end
			S_HI_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_HI;
				nxt           = S_HI_WAIT;
			end
			S_HI_WAIT: begin
				cmd.div_sel = DIV_HI;
				if (!sts.div_busy) begin
					cmd.cap_hi = 1'b1;
					nxt        = S_RANGE;
				end
			end
			S_RANGE: begin
				if (sts.range_empty) begin
					cmd.set_err = 1'b1;
					nxt         = S_EMIT;
				end else begin
					cmd.search_init = 1'b1;
					nxt             = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (sts.cand_ok) begin
					cmd.found = 1'b1;
					nxt       = S_MUL;
				end else if (sts.search_end) begin
					cmd.set_err = 1'b1;
					nxt         = S_EMIT;
				end else begin
					cmd.search_step = 1'b1;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				nxt     = S_RF_GO;
			end
			S_RF_GO: begin
				cmd.div_sel = DIV_RF;
				if (sts.rf_sat_cond) begin
					cmd.rf_sat = 1'b1;
					nxt        = S_DIFF;
				end else begin
					cmd.div_start = 1'b1;
					nxt           = S_RF_WAIT;
				end
			end
			S_RF_WAIT: begin
				cmd.div_sel = DIV_RF;
				if (!sts.div_busy) begin
					cmd.rf_cap = 1'b1;
					nxt        = S_DIFF;
				end
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				nxt      = S_JUDGE;
			end
			S_JUDGE: begin
				cmd.judge = 1'b1;
				nxt       = S_UPD;
			end
			S_UPD: begin
				cmd.upd_anchor = 1'b1;
				nxt            = S_EMIT;
			end
			S_EMIT: begin
				if (sts.slot_free) begin
					cmd.emit = 1'b1;
					if (k_q == count - 1'b1) begin
						nxt = S_IDLE;
					end
				end
			end
			default: begin
				nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= nxt;
			if (state_q != S_EMIT) begin
				k_q <= '0;
			end else if (cmd.emit) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.slot_free)
		else $error("result loaded over an untaken result");
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (k_q < count))
		else $error("result index past end of sequence");
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> sts.div_busy)
		else $error("divider did not start");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_LO_GO))
		else $error("request transfer did not start the search");
`endif

endmodule

### src/dco_divider_search_and_program_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dco_divider_search_and_program_core
// Finds oscillator dividers for a target frequency and emits register writes.
// ----------------------------------------------------------------------------
// Flow: after the request transfer, both bound divisions run, then the search
//   tries six HS dividers per divider value; RFREQ saturation skips its division.
//   One bit-per-cycle divider runs both bound divisions and the RFREQ division.
// Throughput: one request at a time; the next is taken once the last of its
//   1, 7 or 9 results is loaded into the output register.
// Reset: arst_n clears sequencer, anchor and output valid; loads default limits.
module dco_divider_search_and_program_core import dcods_pkg::*; #(
	parameter int OUT_DIV_MAX = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	dcods_in_if.sink    in_ch,
	dcods_out_if.source out_ch,
	dcods_cfg_if.sink   cfg_ch
);

	dp_cmd_t   cmd;
	dp_sts_t   sts;
	out_item_t item;

	// sequencer: owns the request handshake and steps the datapath
	dcods_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// datapath: holds config, anchor and the registered result
	dcods_dp #(
		.OUT_DIV_MAX(OUT_DIV_MAX)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_ch.valid),
		.cfg_index(cfg_ch.index),
		.cfg_data (cfg_ch.data),
		.cfg_ready(cfg_ch.ready),
		.target_hz(in_ch.target_hz),
		.cmd      (cmd),
		.sts      (sts),
		.out_ready(out_ch.ready),
		.out_valid(out_ch.valid),
		.out_item (item)
	);

	// unpack the result register onto the result channel
	assign out_ch.reg_addr     = item.reg_addr;
	assign out_ch.reg_op       = item.reg_op;
	assign out_ch.reg_data     = item.reg_data;
	assign out_ch.no_divider   = item.no_divider;
	assign out_ch.large_change = item.large_change;
	assign out_ch.last         = item.last;

endmodule
